// File: sv/lget_pkg.sv
// ----------------------------------------------------------------------------
// lget_pkg
// Shared types and constants of the light gun event tracker: field widths,
// command, kind and register codes, and the query item of the code table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lget_pkg;

    localparam int CODE_W  = 10;
    localparam int MASK_W  = 12;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 2;
    localparam int FRAC_W  = 16;
    localparam int IDX_W   = 3;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // command codes
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_BIND  = 1'b1;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_KEY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ABS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REL = 2'd2;

    // axis codes and the touch key
    localparam logic [CODE_W-1:0] AXIS_X    = 10'd0;
    localparam logic [CODE_W-1:0] AXIS_Y    = 10'd1;
    localparam logic [CODE_W-1:0] TOUCH_KEY = 10'd330;

    localparam logic signed [VAL_W-1:0] KEY_DOWN = 32'sd1;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_X_LOWER     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_X_UPPER     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_Y_LOWER     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_Y_UPPER     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_REL_MODE    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_TOUCH_CAP   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_TOUCH_START = 3'd6;

    // reset values of the bound registers and the axes
    localparam logic signed [VAL_W-1:0] UPPER_RST = 32'sd32767;
    localparam logic signed [VAL_W-1:0] MID_RST   = 32'sd16383;

    // 2% edge margins: d * 50 < r or d * 50 > r * 49
    localparam int EDGE_DEN  = 50;
    localparam int EDGE_KEEP = 49;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 16'hFFFF;

    typedef struct packed {
        logic              is_bind;
        logic [CODE_W-1:0] code;
        logic [MASK_W-1:0] bmask;
        logic              hit;
        logic              added;
        logic [MASK_W-1:0] mask;
    } t_query;

endpackage

`default_nettype wire

// File: sv/lget_cell.sv
// ----------------------------------------------------------------------------
// lget_cell
// One slot of the code table. Holds a code and its button mask, matches the
// passing query, appends a new code at the fill point and hands the query on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lget_cell
    import lget_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire t_query        i_q,
    input  wire logic [CW-1:0] i_count,
    output logic               o_vld,
    output t_query             o_q
);

    logic              r_vld;
    t_query            r_q;
    t_query            n_q;
    logic [CODE_W-1:0] r_code;
    logic [MASK_W-1:0] r_mask;
    logic              w_live;
    logic              w_match;
    logic              w_append;

    always_comb begin
        w_live   = CW'(IDX) < i_count;
        w_match  = i_vld && !i_q.hit && w_live && (r_code == i_q.code);
        w_append = i_vld && !i_q.hit && i_q.is_bind && (CW'(IDX) == i_count);
        n_q      = i_q;
        if (w_match) begin
            n_q.hit  = 1'b1;
            n_q.mask = r_mask;
        end
        if (w_append) begin
            n_q.hit   = 1'b1;
            n_q.added = 1'b1;
            n_q.mask  = i_q.bmask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_q <= n_q;
        if (w_append) begin
            r_code <= i_q.code;
            r_mask <= i_q.bmask;
        end else if (w_match && i_q.is_bind) begin
            r_mask <= r_mask | i_q.bmask;
        end
    end

    assign o_vld = r_vld;
    assign o_q   = r_q;

endmodule

`default_nettype wire

// File: sv/lget_div.sv
// ----------------------------------------------------------------------------
// lget_div
// Restoring divider for the position fraction: floor(d * 65535 / r) for
// 0 < d < r, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lget_div
    import lget_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [VAL_W-1:0]  i_dividend,
    input  wire logic [VAL_W-1:0]  i_divisor,
    output logic                   o_busy,
    output logic [FRAC_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(FRAC_W + 1);
    localparam int NUM_W = VAL_W + FRAC_W;

    logic [VAL_W-1:0]  r_rem;
    logic [FRAC_W-1:0] r_lo;
    logic [FRAC_W-1:0] r_quot;
    logic [VAL_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [NUM_W-1:0]  w_num;
    logic [VAL_W:0]    w_trial;
    logic              w_ge;
    logic [VAL_W:0]    w_diff;

    always_comb begin
        w_num   = {i_dividend, {FRAC_W{1'b0}}} - NUM_W'(i_dividend);
        w_trial = {r_rem, r_lo[FRAC_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(FRAC_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_rem  <= w_num[NUM_W-1:FRAC_W];
            r_lo   <= w_num[FRAC_W-1:0];
            r_den  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[VAL_W-1:0] : w_trial[VAL_W-1:0];
            r_lo   <= {r_lo[FRAC_W-2:0], 1'b0};
            r_quot <= {r_quot[FRAC_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: sv/light_gun_event_tracker.sv
// ----------------------------------------------------------------------------
// light_gun_event_tracker
// Tracks one pointing gun from input events: code to button table, touch
// state, axis values, and a Q16 aim with a valid bit after every item.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata: code, value, bind mask
//                                            tuser: command, event kind
//   m_axis    out  m_axis_tvalid/tready      tdata: buttons, x, y, flags
//                                            tuser: position valid
//   cfg       in   i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// Key and bind items first walk the row of table cells, one slot a cycle;
// every item then passes the evaluate, prepare, multiply and check states and
// the two fraction dividers. One item at a time; the next is taken while the
// result waits in the output register. Reset is synchronous and clears the
// table fill count, so no clearing pass is needed. cfg is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module light_gun_event_tracker
    import lget_pkg::*;
#(
    parameter int MAP_ENTRIES = 64,
    parameter int REL_RANGE   = 32767,
    parameter int DELTA_SCALE = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [9:0] event_code, [41:10] event_value, [53:42] bind_mask
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // [0] command, [2:1] event_kind
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [11:0] button_bits, [27:12] x_fraction, [43:28] y_fraction,
    // [44] unmapped_press, [45] bind_dropped
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // [0] position_valid
    output logic [M_TUSER_W-1:0]      m_axis_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [IDX_W-1:0]     i_cfg_index,
    input  wire logic [VAL_W-1:0]     i_cfg_data
);

    localparam int CW    = $clog2(MAP_ENTRIES + 1);
    localparam int SUM_W = VAL_W + 2 + $clog2(DELTA_SCALE + 1);
    localparam int RW    = VAL_W + 1;
    localparam int PW    = RW + 6;
    localparam logic signed [VAL_W-1:0] REL_TOP = VAL_W'(REL_RANGE);
    localparam logic signed [VAL_W-1:0] REL_MID = VAL_W'(REL_RANGE / 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_PREP,
        S_MUL,
        S_CHK,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic signed [VAL_W-1:0] r_x_lower, r_x_upper, r_y_lower, r_y_upper;
    logic                    r_rel, r_touch_cap;
    logic signed [VAL_W-1:0] n_x_lower, n_x_upper, n_y_lower, n_y_upper;
    logic                    n_rel;
    logic                    w_cfg_we, w_cfg_axes;
    logic signed [VAL_W:0]   w_sum_x, w_sum_y;
    logic signed [VAL_W-1:0] w_mid_x, w_mid_y;

    // tracker state
    logic [CW-1:0]           r_count;
    logic [MASK_W-1:0]       r_pressed;
    logic                    r_touch_down, r_touch_seen;
    logic signed [VAL_W-1:0] r_x_val, r_y_val;

    // current item
    logic                    r_cmd;
    logic [KIND_W-1:0]       r_kind;
    logic [CODE_W-1:0]       r_code;
    logic signed [VAL_W-1:0] r_val;
    logic [MASK_W-1:0]       r_key_mask;
    logic                    r_unmapped, r_dropped;

    // position
    logic signed [RW-1:0]    r_rx, r_ry, r_dx, r_dy;
    logic signed [PW-1:0]    r_dx50, r_dy50, r_rx49, r_ry49;
    logic                    r_pos_valid;

    // output
    logic                    r_m_tvalid;
    logic [M_TDATA_W-1:0]    r_m_tdata;
    logic [M_TUSER_W-1:0]    r_m_tuser;

    logic                    w_accept;
    logic                    w_cmd;
    logic [KIND_W-1:0]       w_kind;
    logic [CODE_W-1:0]       w_code;
    logic signed [VAL_W-1:0] w_val;
    logic [MASK_W-1:0]       w_bmask;

    t_query                  w_q [MAP_ENTRIES+1];
    logic [MAP_ENTRIES:0]    w_vld;

    logic signed [VAL_W-1:0] w_cur;
    logic signed [SUM_W-1:0] w_scaled, w_sum;
    logic signed [VAL_W-1:0] w_integ;
    logic signed [VAL_W-1:0] w_xl, w_xh, w_yl, w_yh;
    logic signed [PW-1:0]    w_dxw, w_dyw, w_rxw, w_ryw;
    logic                    w_tvalid, w_near_x, w_near_y;
    logic                    w_start, w_busy_x, w_busy_y;
    logic [FRAC_W-1:0]       w_quot_x, w_quot_y;
    logic [FRAC_W-1:0]       w_frac_x, w_frac_y;

    function automatic logic [FRAC_W-1:0] frac_pick(
        input logic                 ok,
        input logic signed [RW-1:0] d,
        input logic signed [RW-1:0] r,
        input logic [FRAC_W-1:0]    q
    );
        logic [FRAC_W-1:0] f;
        if (!ok || d <= 0) begin
            f = '0;
        end else if (d >= r) begin
            f = FRAC_ONE;
        end else begin
            f = q;
        end
        return f;
    endfunction

    // input unpacking
    assign w_cmd   = s_axis_tuser[0];
    assign w_kind  = s_axis_tuser[2:1];
    assign w_code  = s_axis_tdata[CODE_W-1:0];
    assign w_val   = s_axis_tdata[CODE_W+VAL_W-1:CODE_W];
    assign w_bmask = s_axis_tdata[CODE_W+VAL_W+MASK_W-1:CODE_W+VAL_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // configuration decode
    always_comb begin
        w_cfg_we   = i_cfg_valid && o_cfg_ready;
        w_cfg_axes = w_cfg_we && (i_cfg_index inside {[CFG_X_LOWER:CFG_REL_MODE]});
        n_x_lower  = (w_cfg_we && i_cfg_index == CFG_X_LOWER) ? i_cfg_data : r_x_lower;
        n_x_upper  = (w_cfg_we && i_cfg_index == CFG_X_UPPER) ? i_cfg_data : r_x_upper;
        n_y_lower  = (w_cfg_we && i_cfg_index == CFG_Y_LOWER) ? i_cfg_data : r_y_lower;
        n_y_upper  = (w_cfg_we && i_cfg_index == CFG_Y_UPPER) ? i_cfg_data : r_y_upper;
        n_rel      = (w_cfg_we && i_cfg_index == CFG_REL_MODE) ? i_cfg_data[0] : r_rel;
        w_sum_x    = RW'(n_x_lower) + RW'(n_x_upper);
        w_sum_y    = RW'(n_y_lower) + RW'(n_y_upper);
        w_mid_x    = n_rel ? REL_MID : w_sum_x[VAL_W:1];
        w_mid_y    = n_rel ? REL_MID : w_sum_y[VAL_W:1];
    end

    assign o_cfg_ready = 1'b1;

    // code table: a row of cells
    assign w_q[0] = '{is_bind: (w_cmd == CMD_BIND), code: w_code, bmask: w_bmask,
                      hit: 1'b0, added: 1'b0, mask: '0};
    assign w_vld[0] = w_accept && (w_cmd == CMD_BIND || w_kind == KIND_KEY);

    for (genvar g = 0; g < MAP_ENTRIES; g++) begin : g_cell
        lget_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_q     (w_q[g]),
            .i_count (r_count),
            .o_vld   (w_vld[g+1]),
            .o_q     (w_q[g+1])
        );
    end

    // relative integration
    always_comb begin
        w_cur    = (r_code == AXIS_Y) ? r_y_val : r_x_val;
        w_scaled = SUM_W'(r_val) * $signed(SUM_W'(DELTA_SCALE));
        w_sum    = SUM_W'(w_cur) + w_scaled;
        if (w_sum < 0) begin
            w_integ = '0;
        end else if (w_sum > SUM_W'(REL_TOP)) begin
            w_integ = REL_TOP;
        end else begin
            w_integ = w_sum[VAL_W-1:0];
        end
    end

    // bounds, margins and validity
    always_comb begin
        w_xl     = r_rel ? '0 : r_x_lower;
        w_xh     = r_rel ? REL_TOP : r_x_upper;
        w_yl     = r_rel ? '0 : r_y_lower;
        w_yh     = r_rel ? REL_TOP : r_y_upper;
        w_dxw    = PW'(r_dx);
        w_dyw    = PW'(r_dy);
        w_rxw    = PW'(r_rx);
        w_ryw    = PW'(r_ry);
        w_tvalid = r_touch_cap && r_touch_seen;
        w_near_x = (r_dx50 < PW'(r_rx)) || (r_dx50 > r_rx49);
        w_near_y = (r_dy50 < PW'(r_ry)) || (r_dy50 > r_ry49);
        w_frac_x = frac_pick(r_pos_valid, r_dx, r_rx, w_quot_x);
        w_frac_y = frac_pick(r_pos_valid, r_dy, r_ry, w_quot_y);
    end

    assign w_start = (r_state == S_CHK);

    lget_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_dx[VAL_W-1:0]),
        .i_divisor  (r_rx[VAL_W-1:0]),
        .o_busy     (w_busy_x),
        .o_quot     (w_quot_x)
    );

    lget_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (r_dy[VAL_W-1:0]),
        .i_divisor  (r_ry[VAL_W-1:0]),
        .o_busy     (w_busy_y),
        .o_quot     (w_quot_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_x_lower    <= '0;
            r_x_upper    <= UPPER_RST;
            r_y_lower    <= '0;
            r_y_upper    <= UPPER_RST;
            r_rel        <= 1'b0;
            r_touch_cap  <= 1'b0;
            r_count      <= '0;
            r_pressed    <= '0;
            r_touch_down <= 1'b0;
            r_touch_seen <= 1'b0;
            r_x_val      <= MID_RST;
            r_y_val      <= MID_RST;
            r_m_tvalid   <= 1'b0;
        end else begin
            r_x_lower <= n_x_lower;
            r_x_upper <= n_x_upper;
            r_y_lower <= n_y_lower;
            r_y_upper <= n_y_upper;
            r_rel     <= n_rel;
            if (w_cfg_we && i_cfg_index == CFG_TOUCH_CAP) begin
                r_touch_cap <= i_cfg_data[0];
            end
            if (w_cfg_we && i_cfg_index == CFG_TOUCH_START) begin
                r_touch_down <= i_cfg_data[0];
                r_touch_seen <= i_cfg_data[0];
            end
            if (w_cfg_axes) begin
                r_x_val <= w_mid_x;
                r_y_val <= w_mid_y;
            end
            if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd      <= w_cmd;
                        r_kind     <= w_kind;
                        r_code     <= w_code;
                        r_val      <= w_val;
                        r_key_mask <= '0;
                        r_unmapped <= 1'b0;
                        r_dropped  <= 1'b0;
                        r_state    <= w_vld[0] ? S_SCAN : S_EVAL;
                    end
                end
                S_SCAN: begin
                    if (w_vld[MAP_ENTRIES]) begin
                        r_key_mask <= w_q[MAP_ENTRIES].hit ? w_q[MAP_ENTRIES].mask : '0;
                        r_dropped  <= w_q[MAP_ENTRIES].is_bind && !w_q[MAP_ENTRIES].hit;
                        if (w_q[MAP_ENTRIES].added) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_cmd == CMD_EVENT) begin
                        case (r_kind)
                            KIND_KEY: begin
                                if (r_code == TOUCH_KEY) begin
                                    r_touch_down <= (r_val != 0);
                                    r_touch_seen <= 1'b1;
                                end
                                if (r_key_mask != '0) begin
                                    if (r_val != 0) begin
                                        r_pressed <= r_pressed | r_key_mask;
                                    end else begin
                                        r_pressed <= r_pressed & ~r_key_mask;
                                    end
                                end else if (r_code != TOUCH_KEY && r_val == KEY_DOWN) begin
                                    r_unmapped <= 1'b1;
                                end
                            end
                            KIND_ABS: begin
                                if (r_code == AXIS_X) begin
                                    r_x_val <= r_val;
                                end else if (r_code == AXIS_Y) begin
                                    r_y_val <= r_val;
                                end
                            end
                            KIND_REL: begin
                                if (r_rel && r_code == AXIS_X) begin
                                    r_x_val <= w_integ;
                                end else if (r_rel && r_code == AXIS_Y) begin
                                    r_y_val <= w_integ;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_rx    <= RW'(w_xh) - RW'(w_xl);
                    r_ry    <= RW'(w_yh) - RW'(w_yl);
                    r_dx    <= RW'(r_x_val) - RW'(w_xl);
                    r_dy    <= RW'(r_y_val) - RW'(w_yl);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_dx50  <= w_dxw * $signed(PW'(EDGE_DEN));
                    r_dy50  <= w_dyw * $signed(PW'(EDGE_DEN));
                    r_rx49  <= w_rxw * $signed(PW'(EDGE_KEEP));
                    r_ry49  <= w_ryw * $signed(PW'(EDGE_KEEP));
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_pos_valid <= !(w_tvalid && !r_touch_down)
                                && (r_rx > 0) && (r_ry > 0)
                                && !(!r_rel && !w_tvalid && (w_near_x || w_near_y));
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_busy_x && !w_busy_y) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_m_tvalid || m_axis_tready) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {2'b00, r_dropped, r_unmapped,
                                       w_frac_y, w_frac_x, r_pressed};
                        r_m_tuser  <= r_pos_valid;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) <= 1)
        else $error("more than one query in the cell row");

    a_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[MAP_ENTRIES] |-> r_state == S_SCAN)
        else $error("query left the cell row outside a scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAP_ENTRIES))
        else $error("table fill count beyond its depth");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_vld[MAP_ENTRIES] && w_q[MAP_ENTRIES].is_bind
         && !w_q[MAP_ENTRIES].hit) |-> r_count == CW'(MAP_ENTRIES))
        else $error("bind dropped while the table has room");

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the light gun event tracker. A scoreboard keeps its
// own copy of the code table, buttons, touch state and axes, predicts the
// report of every accepted event and compares it field by field with the
// block's output. Several register settings are run, each after the block
// has drained: absolute and relative modes, extreme and empty axis ranges,
// and touch on and off. Events are a mix of binds, keys, axis moves and
// noise, with random gaps and stalls, one long receiver hold and a
// final stretch with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import lget_pkg::*;

    localparam int MAP_ENTRIES = 64;
    localparam int REL_RANGE   = 32767;
    localparam int DELTA_SCALE = 8;

    localparam int CODE_MAX    = 767;
    localparam int POOL_SIZE   = 12;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 200;
    localparam int CYCLE_LIMIT = 600000;

    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;
    localparam logic [IDX_W-1:0]  CFG_UNUSED = 3'd7;

    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S32_MAX = 64'sd2147483647;

    localparam logic [CODE_W-1:0] KEY_POOL [POOL_SIZE] = '{
        10'd0, 10'd1, 10'd5, 10'd100, 10'd272, 10'd273,
        10'd274, 10'd288, TOUCH_KEY, 10'd512, 10'd700, 10'd767
    };

    typedef struct packed {
        logic                     cmd;
        logic [KIND_W-1:0]        kind;
        logic [CODE_W-1:0]        code;
        logic signed [VAL_W-1:0]  value;
        logic [MASK_W-1:0]        bmask;
    } gun_event_t;

    typedef struct packed {
        logic [MASK_W-1:0] buttons;
        logic              pos_valid;
        logic [FRAC_W-1:0] x_frac;
        logic [FRAC_W-1:0] y_frac;
        logic              unmapped;
        logic              dropped;
    } gun_report_t;

    class gun_scoreboard;
        longint x_lo, x_hi, y_lo, y_hi;
        bit rel_mode, touch_cap;
        logic [CODE_W-1:0] codes [MAP_ENTRIES];
        logic [MASK_W-1:0] masks [MAP_ENTRIES];
        int n_codes;
        logic [MASK_W-1:0] pressed;
        bit touch_down, touch_seen;
        longint x_val, y_val;
        gun_report_t pending_reports [$];
        int errors;

        function new();
            x_lo = 0;
            x_hi = UPPER_RST;
            y_lo = 0;
            y_hi = UPPER_RST;
            rel_mode = 0;
            touch_cap = 0;
            n_codes = 0;
            pressed = '0;
            touch_down = 0;
            touch_seen = 0;
            errors = 0;
            load_axes();
        endfunction

        function void load_axes();
            if (rel_mode) begin
                x_val = REL_RANGE / 2;
                y_val = REL_RANGE / 2;
            end else begin
                x_val = (x_lo + x_hi) >>> 1;
                y_val = (y_lo + y_hi) >>> 1;
            end
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] data);
            case (idx)
                CFG_X_LOWER: begin
                    x_lo = $signed(data);
                    load_axes();
                end
                CFG_X_UPPER: begin
                    x_hi = $signed(data);
                    load_axes();
                end
                CFG_Y_LOWER: begin
                    y_lo = $signed(data);
                    load_axes();
                end
                CFG_Y_UPPER: begin
                    y_hi = $signed(data);
                    load_axes();
                end
                CFG_REL_MODE: begin
                    rel_mode = data[0];
                    load_axes();
                end
                CFG_TOUCH_CAP: touch_cap = data[0];
                CFG_TOUCH_START: begin
                    touch_down = data[0];
                    touch_seen = data[0];
                end
                default: ;
            endcase
        endfunction

        function int find_slot(logic [CODE_W-1:0] code);
            for (int i = 0; i < n_codes; i++)
                if (codes[i] == code)
                    return i;
            return -1;
        endfunction

        function longint saturate(longint v, longint delta);
            longint n;
            n = v + delta * DELTA_SCALE;
            if (n < 0)
                n = 0;
            if (n > REL_RANGE)
                n = REL_RANGE;
            return n;
        endfunction

        function bit near_edge(longint d, longint r);
            return d * EDGE_DEN < r || d * EDGE_DEN > r * EDGE_KEEP;
        endfunction

        function logic [FRAC_W-1:0] fraction(longint d, longint r);
            if (d <= 0)
                return '0;
            if (d >= r)
                return FRAC_ONE;
            return FRAC_W'((d * 65535) / r);
        endfunction

        // update the tracked state with one item and queue the report it gives
        function void note_event(gun_event_t ev);
            gun_report_t r;
            int slot;
            longint v, xl, xh, yl, yh, rx, ry, dx, dy;
            logic [MASK_W-1:0] m;
            bit trusted;
            r = '0;
            v = $signed(ev.value);
            if (ev.cmd == CMD_BIND) begin
                slot = find_slot(ev.code);
                if (slot >= 0) begin
                    masks[slot] = masks[slot] | ev.bmask;
                end else if (n_codes < MAP_ENTRIES) begin
                    codes[n_codes] = ev.code;
                    masks[n_codes] = ev.bmask;
                    n_codes++;
                end else begin
                    r.dropped = 1'b1;
                end
            end else if (ev.kind == KIND_KEY) begin
                m = '0;
                if (ev.code == TOUCH_KEY) begin
                    touch_down = v != 0;
                    touch_seen = 1;
                end
                slot = find_slot(ev.code);
                if (slot >= 0)
                    m = masks[slot];
                if (m != 0) begin
                    if (v != 0)
                        pressed = pressed | m;
                    else
                        pressed = pressed & ~m;
                end else if (ev.code != TOUCH_KEY && v == 1) begin
                    r.unmapped = 1'b1;
                end
            end else if (ev.kind == KIND_ABS) begin
                if (ev.code == AXIS_X)
                    x_val = v;
                else if (ev.code == AXIS_Y)
                    y_val = v;
            end else if (ev.kind == KIND_REL && rel_mode) begin
                if (ev.code == AXIS_X)
                    x_val = saturate(x_val, v);
                else if (ev.code == AXIS_Y)
                    y_val = saturate(y_val, v);
            end

            if (rel_mode) begin
                xl = 0;
                xh = REL_RANGE;
                yl = 0;
                yh = REL_RANGE;
            end else begin
                xl = x_lo;
                xh = x_hi;
                yl = y_lo;
                yh = y_hi;
            end
            rx = xh - xl;
            ry = yh - yl;
            dx = x_val - xl;
            dy = y_val - yl;
            trusted = touch_cap && touch_seen;

            r.pos_valid = 1'b1;
            if (trusted && !touch_down)
                r.pos_valid = 1'b0;
            else if (rx <= 0 || ry <= 0)
                r.pos_valid = 1'b0;
            else if (!rel_mode && !trusted && (near_edge(dx, rx) || near_edge(dy, ry)))
                r.pos_valid = 1'b0;

            r.buttons = pressed;
            if (r.pos_valid) begin
                r.x_frac = fraction(dx, rx);
                r.y_frac = fraction(dy, ry);
            end
            pending_reports.push_back(r);
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(gun_report_t got);
            gun_report_t want;
            if (pending_reports.size() == 0) begin
                $error("report with nothing expected: buttons %03h", got.buttons);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            cmp_field("button_bits", want.buttons, got.buttons);
            cmp_field("position_valid", want.pos_valid, got.pos_valid);
            cmp_field("x_fraction", want.x_frac, got.x_frac);
            cmp_field("y_fraction", want.y_frac, got.y_frac);
            cmp_field("unmapped_press", want.unmapped, got.unmapped);
            cmp_field("bind_dropped", want.dropped, got.dropped);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [VAL_W-1:0]     i_cfg_data = '0;

    gun_scoreboard sb;
    gun_report_t   got_report;
    bit            quiet = 1'b0;
    int unsigned   hold_seq = 0;
    int unsigned   hold_seen = 0;
    int unsigned   hold_left = 0;
    int unsigned   stall_left = 0;
    int unsigned   cycle_count = 0;

    light_gun_event_tracker #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .REL_RANGE   (REL_RANGE),
        .DELTA_SCALE (DELTA_SCALE)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial sb = new();

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: long hold on request, else short random stalls
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            got_report.buttons   = m_axis_tdata[11:0];
            got_report.x_frac    = m_axis_tdata[27:12];
            got_report.y_frac    = m_axis_tdata[43:28];
            got_report.unmapped  = m_axis_tdata[44];
            got_report.dropped   = m_axis_tdata[45];
            got_report.pos_valid = m_axis_tuser[0];
            sb.check_result(got_report);
        end
    end

    function automatic gun_event_t mk_event(logic cmd, logic [KIND_W-1:0] kind,
                                            logic [CODE_W-1:0] code, longint val,
                                            logic [MASK_W-1:0] bmask);
        gun_event_t ev;
        ev.cmd = cmd;
        ev.kind = kind;
        ev.code = code;
        ev.value = val[31:0];
        ev.bmask = bmask;
        return ev;
    endfunction

    function automatic gun_event_t random_event();
        gun_event_t ev;
        int unsigned sel;
        int off;
        longint lo, hi, r, v;
        ev.cmd = CMD_EVENT;
        ev.kind = KIND_KEY;
        ev.code = KEY_POOL[$urandom_range(0, POOL_SIZE - 1)];
        ev.value = $urandom;
        ev.bmask = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            ev.cmd = CMD_BIND;
            ev.kind = $urandom;
            if ($urandom_range(0, 9) < 3)
                ev.code = $urandom_range(0, CODE_MAX);
            if ($urandom_range(0, 7) == 0)
                ev.bmask = '0;
        end else if (sel < 55) begin
            sel = $urandom_range(0, 19);
            if (sel < 3)
                ev.code = TOUCH_KEY;
            else if (sel < 7)
                ev.code = $urandom_range(0, CODE_MAX);
            sel = $urandom_range(0, 9);
            if (sel < 4)
                ev.value = 0;
            else if (sel < 8)
                ev.value = KEY_DOWN;
            else if (sel == 8)
                ev.value = $urandom_range(2, 3);
        end else if (sel < 80) begin
            ev.kind = KIND_ABS;
            if ($urandom_range(0, 9) == 0)
                ev.code = $urandom_range(2, CODE_MAX);
            else
                ev.code = $urandom_range(0, 1) ? AXIS_Y : AXIS_X;
            if (sb.rel_mode) begin
                lo = 0;
                hi = REL_RANGE;
            end else begin
                lo = (ev.code == AXIS_Y) ? sb.y_lo : sb.x_lo;
                hi = (ev.code == AXIS_Y) ? sb.y_hi : sb.x_hi;
            end
            r = hi - lo;
            sel = $urandom_range(0, 9);
            off = $urandom_range(0, 4);
            if (r > 0 && sel < 5) begin
                v = lo + longint'({$urandom, $urandom} % (r + 1));
                ev.value = v[31:0];
            end else if (r > 0 && sel < 8) begin
                v = ((sel == 5) ? lo + r / EDGE_DEN : hi - r / EDGE_DEN) + off - 2;
                ev.value = v[31:0];
            end else if (sel == 8) begin
                v = ((off < 2) ? lo : hi) + off - 2;
                ev.value = v[31:0];
            end
        end else if (sel < 92) begin
            ev.kind = KIND_REL;
            if ($urandom_range(0, 9) == 0)
                ev.code = $urandom_range(2, CODE_MAX);
            else
                ev.code = $urandom_range(0, 1) ? AXIS_Y : AXIS_X;
            sel = $urandom_range(0, 5);
            if (sel < 4) begin
                off = $urandom_range(0, 200);
                ev.value = off - 100;
            end else if (sel == 4) begin
                off = $urandom_range(0, 10000);
                ev.value = off - 5000;
            end
        end else begin
            ev.kind = KIND_OTHER;
            ev.code = $urandom_range(0, CODE_MAX);
        end
        return ev;
    endfunction

    task automatic send_event(gun_event_t ev);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, ev.bmask, ev.value, ev.code};
        s_axis_tuser  <= {ev.kind, ev.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_event(ev);
    endtask

    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(longint xl, longint xu, longint yl, longint yu,
                             bit rel, bit cap, bit at_start, int n_items,
                             bit long_hold, bit last);
        logic [IDX_W-1:0] idx [8];
        logic [VAL_W-1:0] dat [8];
        idx = '{CFG_UNUSED, CFG_X_LOWER, CFG_X_UPPER, CFG_Y_LOWER, CFG_Y_UPPER,
                CFG_REL_MODE, CFG_TOUCH_CAP, CFG_TOUCH_START};
        dat = '{$urandom, xl[31:0], xu[31:0], yl[31:0], yu[31:0],
                {31'd0, rel}, {31'd0, cap}, {31'd0, at_start}};
        wait_for_reports();
        for (int k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= dat[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx[k], dat[k]);
        end
        i_cfg_valid <= 1'b0;
        if (last)
            quiet <= 1'b1;
        for (int n = 0; n < n_items; n++) begin
            if (long_hold && n == 20)
                hold_seq <= hold_seq + 1;
            send_event(random_event());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items in the reset setting
        send_event(mk_event(CMD_EVENT, KIND_KEY, 10'd5, 1, '0));
        send_event(mk_event(CMD_BIND, KIND_KEY, 10'd5, 0, 12'h000));
        send_event(mk_event(CMD_EVENT, KIND_KEY, 10'd5, 1, '0));
        send_event(mk_event(CMD_BIND, KIND_ABS, 10'd5, 7, 12'h001));
        send_event(mk_event(CMD_BIND, KIND_REL, 10'd5, -1, 12'h800));
        send_event(mk_event(CMD_EVENT, KIND_KEY, 10'd5, 2, '0));
        send_event(mk_event(CMD_EVENT, KIND_KEY, 10'd5, 0, '0));
        send_event(mk_event(CMD_EVENT, KIND_KEY, 10'd767, 1, '0));
        send_event(mk_event(CMD_EVENT, KIND_KEY, 10'd7, 2, '0));
        send_event(mk_event(CMD_EVENT, KIND_KEY, TOUCH_KEY, 1, '0));
        send_event(mk_event(CMD_EVENT, KIND_KEY, TOUCH_KEY, 0, '0));
        send_event(mk_event(CMD_EVENT, KIND_ABS, AXIS_X, 0, '0));
        send_event(mk_event(CMD_EVENT, KIND_ABS, AXIS_X, 32767, '0));
        send_event(mk_event(CMD_EVENT, KIND_ABS, AXIS_X, 16383, '0));
        send_event(mk_event(CMD_EVENT, KIND_ABS, AXIS_Y, 655, '0));
        send_event(mk_event(CMD_EVENT, KIND_ABS, AXIS_Y, 656, '0));
        send_event(mk_event(CMD_EVENT, KIND_ABS, AXIS_X, S32_MIN, '0));
        send_event(mk_event(CMD_EVENT, KIND_ABS, AXIS_X, S32_MAX, '0));
        send_event(mk_event(CMD_EVENT, KIND_ABS, AXIS_X, 20000, '0));
        send_event(mk_event(CMD_EVENT, KIND_REL, AXIS_X, 5, '0));
        send_event(mk_event(CMD_EVENT, KIND_OTHER, AXIS_Y, 100, 12'hFFF));
        send_event(mk_event(CMD_EVENT, KIND_ABS, 10'd2, 9, '0));
        send_event(mk_event(CMD_BIND, KIND_OTHER, 10'd767, -1, 12'hFFF));
        send_event(mk_event(CMD_EVENT, KIND_KEY, 10'd767, -1, '0));
        send_event(mk_event(CMD_EVENT, KIND_KEY, 10'd767, 0, '0));

        // random items over a series of settings
        run_phase(0, 32767, 0, 32767, 0, 0, 0, 150, 0, 0);
        run_phase(S32_MIN, S32_MAX, -1000, 1000, 0, 0, 0, 150, 1, 0);
        run_phase(100, 1100, -500, 300, 0, 1, 1, 150, 0, 0);
        run_phase(0, 0, 0, 0, 1, 1, 0, 160, 0, 0);
        run_phase(500, 500, S32_MAX, S32_MIN, 0, 0, 1, 100, 0, 0);
        run_phase(-20000, -19950, 0, 4095, 0, 1, 0, 160, 0, 0);
        run_phase(7, 7, 7, 7, 1, 0, 1, 160, 0, 0);
        run_phase(-32768, 32767, -32768, 32767, 0, 0, 0, 220, 0, 1);

        wait_for_reports();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
sv/lget_pkg.sv
sv/lget_cell.sv
sv/lget_div.sv
sv/light_gun_event_tracker.sv
sim/tb.sv
